// File: hdl/sqi_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the squared integral image block.
// No dependencies; used by the output buffer and the top level.
package sqi_pkg;

	// Field widths fixed by the stream format
	localparam int PIXEL_W   = 8;
	localparam int SQ_W      = 36;
	localparam int TDATA_W   = 40;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	// Reset value of both size registers
	localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;

	// One finished result word
	typedef struct packed {
		logic            frame_end;
		logic            row_end;
		logic [SQ_W-1:0] sq_integral;
	} sqi_result_t;

endpackage

// File: hdl/sqi_line_buf.sv
`timescale 1ns / 1ps
// Line buffer: one-port-write, one-port-read synchronous memory holding the
// previous row's integral values. Registered read, old data on collision.
module sqi_line_buf #(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10,
	parameter int DATA_W = 36
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	// Write back the updated column value
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Fetch the column value of the row above
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: hdl/sqi_out_buf.sv
`timescale 1ns / 1ps
// Three-word output queue between the compute stage and the result stream.
// Depends on sqi_pkg for the result word type.
module sqi_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sqi_pkg::sqi_result_t push_word,
	output logic                out_valid,
	input  logic                out_ready,
	output sqi_pkg::sqi_result_t out_word,
	output logic [1:0]          fill
);

	localparam logic [1:0] LAST_SLOT = 2'd2;

	sqi_pkg::sqi_result_t slot_q [3];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [1:0] fill_q;
	logic       pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (fill_q != 2'd0);
	assign out_word  = slot_q[rd_ptr_q];
	assign fill      = fill_q;

	// Store incoming words
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_word;
		end
	end

	// Advance pointers and track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? 2'd0 : wr_ptr_q + 2'd1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? 2'd0 : rd_ptr_q + 2'd1;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// File: hdl/squared_integral_image.sv
`timescale 1ns / 1ps
// Squared integral image, streamed one pixel per clock while s_tready is high.
// Depends on sqi_pkg, sqi_line_buf and sqi_out_buf.
//
//  channel   dir  handshake            payload
//  --------  ---  -------------------  ---------------------------------------
//  s_        in   s_tvalid / s_tready  s_tdata = pixel
//  m_        out  m_tvalid / m_tready  m_tdata = sq_integral, m_tlast = row_end,
//                                      m_tuser = frame_end
//  cfg_      in   cfg_valid/cfg_ready  cfg_index = register, cfg_data = value
//
// One pixel per clock sustained while the output queue has room; each taken pixel
// goes through the line buffer read-modify-write stage, which pushes its result.
// The registered line buffer read is covered by forwarding when the same
// column is written and read back to back (a row width of one).
// A three-word output queue lets input continue while results wait; the input
// stalls once the queue and the compute stage together hold three words.
// Reset clears counters, row sum and size registers (both 1024); the line
// buffer is not cleared, every row after the first reads entries the row
// above has written.
module squared_integral_image #(
	parameter int MAX_COLS = 1024,
	parameter int MAX_ROWS = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// pixel word: [7:0] pixel
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [sqi_pkg::PIXEL_W-1:0]       s_tdata,
	// result word: [35:0] sq_integral, [39:36] zero
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [sqi_pkg::TDATA_W-1:0]       m_tdata,
	output logic                              m_tlast,
	// [0] frame_end
	output logic                              m_tuser,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sqi_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sqi_pkg::CFG_W-1:0]         cfg_data
);

	localparam int CW     = $clog2(MAX_COLS);
	localparam int RW     = $clog2(MAX_ROWS);
	localparam int RCW    = (MAX_ROWS > 1) ? RW : 1;
	localparam int RS_W   = CW + 2 * sqi_pkg::PIXEL_W;
	localparam int FULL_W = CW + RW + 2 * sqi_pkg::PIXEL_W;
	localparam int VAL_W  = (FULL_W < sqi_pkg::SQ_W) ? FULL_W : sqi_pkg::SQ_W;
	localparam int SQR_W  = 2 * sqi_pkg::PIXEL_W;

	// Last index in use for a size register value: zero acts as one,
	// anything above the maximum saturates
	function automatic int last_index(input logic [sqi_pkg::CFG_W-1:0] v, input int maxv);
		int r;
		if (v == '0) begin
			r = 0;
		end else if (int'(v) > maxv) begin
			r = maxv - 1;
		end else begin
			r = int'(v) - 1;
		end
		return r;
	endfunction

	// Size registers, kept as last column and last row index
	logic [CW-1:0]  col_last_q;
	logic [RCW-1:0] row_last_q;

	// Position and running row sum
	logic [CW-1:0]   col_q;
	logic [RCW-1:0]  row_q;
	logic [RS_W-1:0] row_sum_q;

	// Compute stage
	logic              valid_s1;
	logic [CW-1:0]     addr_s1;
	logic [RS_W-1:0]   row_sum_s1;
	logic              first_row_s1;
	logic              row_end_s1;
	logic              frame_end_s1;
	logic              fwd_s1;
	logic [VAL_W-1:0]  fwd_data_s1;

	logic                 accept;
	logic [SQR_W-1:0]     pix_sq;
	logic [RS_W-1:0]      row_sum_next;
	logic                 row_end;
	logic                 frame_end;
	logic [VAL_W-1:0]     above;
	logic [VAL_W-1:0]     rd_data;
	logic [VAL_W-1:0]     value_s1;
	logic [1:0]           fill;
	logic [2:0]           occupancy;
	sqi_pkg::sqi_result_t push_word;
	sqi_pkg::sqi_result_t out_word;

	assign cfg_ready = 1'b1;

	// Take a size register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_last_q <= CW'(last_index(sqi_pkg::SIZE_RESET, MAX_COLS));
			row_last_q <= RCW'(last_index(sqi_pkg::SIZE_RESET, MAX_ROWS));
		end else if (cfg_valid) begin
			case (cfg_index)
				sqi_pkg::REG_IMAGE_WIDTH:  col_last_q <= CW'(last_index(cfg_data, MAX_COLS));
				sqi_pkg::REG_IMAGE_HEIGHT: row_last_q <= RCW'(last_index(cfg_data, MAX_ROWS));
				default: ;
			endcase
		end
	end

	// Accept while the queue plus the compute stage hold at most two words
	assign occupancy = {1'b0, fill} + {2'b00, valid_s1};
	assign s_tready  = (occupancy <= 3'd2);
	assign accept    = s_tvalid && s_tready;

	// Square the pixel and extend the row sum
	assign pix_sq       = {{sqi_pkg::PIXEL_W{1'b0}}, s_tdata}
	                    * {{sqi_pkg::PIXEL_W{1'b0}}, s_tdata};
	assign row_sum_next = row_sum_q + RS_W'(pix_sq);
	assign row_end      = (col_q >= col_last_q);
	assign frame_end    = row_end && (row_q >= row_last_q);

	// Advance counters and row sum on each accepted pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			row_sum_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q     <= '0;
				row_sum_q <= '0;
				row_q     <= frame_end ? '0 : row_q + 1'b1;
			end else begin
				col_q     <= col_q + 1'b1;
				row_sum_q <= row_sum_next;
			end
		end
	end

	// Hold the pixel's context for the read-modify-write stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1      <= col_q;
			row_sum_s1   <= row_sum_next;
			first_row_s1 <= (row_q == '0);
			row_end_s1   <= row_end;
			frame_end_s1 <= frame_end;
			fwd_s1       <= valid_s1 && (addr_s1 == col_q);
			fwd_data_s1  <= value_s1;
		end
	end

	sqi_line_buf #(
		.DEPTH  (MAX_COLS),
		.ADDR_W (CW),
		.DATA_W (VAL_W)
	) u_line_buf (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (rd_data),
		.wr_en   (valid_s1),
		.wr_addr (addr_s1),
		.wr_data (value_s1)
	);

	// Add the row above, taking a value written in the same cycle as the read
	assign above    = fwd_s1 ? fwd_data_s1 : rd_data;
	assign value_s1 = first_row_s1 ? VAL_W'(row_sum_s1) : above + VAL_W'(row_sum_s1);

	assign push_word.frame_end   = frame_end_s1;
	assign push_word.row_end     = row_end_s1;
	assign push_word.sq_integral = sqi_pkg::SQ_W'(value_s1);

	sqi_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.push_word (push_word),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_word  (out_word),
		.fill      (fill)
	);

	assign m_tdata = sqi_pkg::TDATA_W'(out_word.sq_integral);
	assign m_tlast = out_word.row_end;
	assign m_tuser = out_word.frame_end;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for squared_integral_image: random pixel streams over many frame sizes.
// Depends on sqi_pkg and the squared_integral_image RTL with its line and output buffers.
module tb_top;

	localparam int MAX_COLS    = 1024;
	localparam int MAX_ROWS    = 1024;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLDOFF_LEN = 300;

	logic                                 clk       = 1'b0;
	logic                                 arst_n    = 1'b0;
	logic                                 s_tvalid  = 1'b0;
	logic                                 s_tready;
	logic [sqi_pkg::PIXEL_W-1:0]          s_tdata   = '0;
	logic                                 m_tvalid;
	logic                                 m_tready  = 1'b0;
	logic [sqi_pkg::TDATA_W-1:0]          m_tdata;
	logic                                 m_tlast;
	logic                                 m_tuser;
	logic                                 cfg_valid = 1'b0;
	logic                                 cfg_ready;
	logic [sqi_pkg::CFG_IDX_W-1:0]        cfg_index = sqi_pkg::REG_IMAGE_WIDTH;
	logic [sqi_pkg::CFG_W-1:0]            cfg_data  = '0;

	// Stimulus and scoreboard
	logic [sqi_pkg::PIXEL_W-1:0] pixel_q[$];
	sqi_pkg::sqi_result_t        expected_results[$];
	int unsigned        pixels_queued   = 0;
	int unsigned        pixels_accepted = 0;
	int unsigned        fail_count      = 0;
	int unsigned        cycle_count     = 0;
	int unsigned        src_idle_pct    = 38;
	int unsigned        snk_idle_pct    = 38;
	int unsigned        holdoff_req     = 0;
	int unsigned        holdoff_seen    = 0;
	int unsigned        holdoff_left    = 0;

	// Mirror of the block: size registers, row sum, line buffer, counters
	logic [sqi_pkg::CFG_W-1:0] cfg_width  = sqi_pkg::SIZE_RESET;
	logic [sqi_pkg::CFG_W-1:0] cfg_height = sqi_pkg::SIZE_RESET;
	logic [36:0]      row_sq     = '0;
	logic [36:0]      line_buf[MAX_COLS];
	int unsigned      col_pos    = 0;
	int unsigned      row_pos    = 0;
	int unsigned      written_hi = 0;

	squared_integral_image #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// Size in use: zero acts as one, anything above the maximum saturates
	function automatic int unsigned size_in_use(input logic [sqi_pkg::CFG_W-1:0] v,
	                                            input int unsigned maxv);
		if (v == 0)
			return 1;
		if (v > maxv)
			return maxv;
		return v;
	endfunction

	// Advance the mirror by one pixel and queue the word it must produce
	function automatic void predict_sq_integral(input logic [sqi_pkg::PIXEL_W-1:0] px);
		int unsigned w_eff;
		int unsigned h_eff;
		int unsigned col;
		logic [36:0] val;
		sqi_pkg::sqi_result_t word;
		w_eff  = size_in_use(cfg_width, MAX_COLS);
		h_eff  = size_in_use(cfg_height, MAX_ROWS);
		col    = col_pos % MAX_COLS;
		row_sq = row_sq + 37'(px) * 37'(px);
		if (row_pos == 0)
			val = row_sq;
		else
			val = line_buf[col] + row_sq;
		line_buf[col] = val;
		if (col + 1 > written_hi)
			written_hi = col + 1;
		word.sq_integral = val[sqi_pkg::SQ_W-1:0];
		word.row_end     = (col_pos + 1) >= w_eff;
		word.frame_end   = word.row_end && ((row_pos + 1) >= h_eff);
		expected_results.push_back(word);
		if (word.row_end) begin
			col_pos = 0;
			row_sq  = '0;
			if (word.frame_end)
				row_pos = 0;
			else
				row_pos++;
		end else begin
			col_pos++;
		end
	endfunction

	// Pixel driver: predict on each accepted word, then offer the next one or idle
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				predict_sq_integral(s_tdata);
				pixels_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (pixel_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= pixel_q.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare each accepted word with the oldest expectation
	always @(posedge clk) begin
		sqi_pkg::sqi_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result word: sq_integral %0d",
						m_tdata[sqi_pkg::SQ_W-1:0]);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (m_tdata[sqi_pkg::SQ_W-1:0] !== want.sq_integral) begin
						$error("sq_integral: expected %0d, got %0d",
							want.sq_integral, m_tdata[sqi_pkg::SQ_W-1:0]);
						fail_count++;
					end
					if (m_tdata[sqi_pkg::TDATA_W-1:sqi_pkg::SQ_W] !== '0) begin
						$error("tdata padding: expected 0, got %0h",
							m_tdata[sqi_pkg::TDATA_W-1:sqi_pkg::SQ_W]);
						fail_count++;
					end
					if (m_tlast !== want.row_end) begin
						$error("row_end: expected %0b, got %0b", want.row_end, m_tlast);
						fail_count++;
					end
					if (m_tuser !== want.frame_end) begin
						$error("frame_end: expected %0b, got %0b", want.frame_end, m_tuser);
						fail_count++;
					end
				end
			end
			// Hold off for a long stretch on request, otherwise stall at random
			if (holdoff_req != holdoff_seen) begin
				holdoff_seen = holdoff_req;
				holdoff_left = HOLDOFF_LEN;
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Write one size register; the block is idle whenever this is called
	task automatic write_size(input logic [sqi_pkg::CFG_IDX_W-1:0] idx,
	                          input logic [sqi_pkg::CFG_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == sqi_pkg::REG_IMAGE_WIDTH)
			cfg_width = value;
		else
			cfg_height = value;
	endtask

	task automatic send_pixel(input logic [sqi_pkg::PIXEL_W-1:0] px);
		pixel_q.push_back(px);
		pixels_queued++;
	endtask

	// Wait until every pixel is taken and every word has come back
	task automatic wait_drained();
		while (pixels_accepted != pixels_queued || expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [sqi_pkg::PIXEL_W-1:0] random_pixel();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 25)
			return 8'hFF;
		if (r < 35)
			return 8'h00;
		return 8'($urandom_range(255));
	endfunction

	initial begin
		int unsigned random_items;
		int unsigned phase;
		int unsigned n;
		int unsigned area;
		int unsigned sel;
		int unsigned r;
		logic [sqi_pkg::CFG_W-1:0] new_w;
		logic [sqi_pkg::CFG_W-1:0] new_h;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset sizes: start a long first row
		send_pixel(8'hFF);
		send_pixel(8'h00);
		send_pixel(8'h80);
		wait_drained();

		// Width zero acts as one, shrinking mid-row ends the row at once
		write_size(sqi_pkg::REG_IMAGE_WIDTH, 11'd0);
		write_size(sqi_pkg::REG_IMAGE_HEIGHT, 11'd3);
		repeat (3) send_pixel(8'hFF);
		send_pixel(8'h01);
		send_pixel(8'h02);
		send_pixel(8'h04);
		wait_drained();

		// Height zero acts as one: every row closes a frame
		write_size(sqi_pkg::REG_IMAGE_WIDTH, 11'd3);
		write_size(sqi_pkg::REG_IMAGE_HEIGHT, 11'd0);
		send_pixel(8'h08);
		send_pixel(8'h10);
		send_pixel(8'h20);
		send_pixel(8'h40);
		send_pixel(8'h80);
		send_pixel(8'hFF);
		wait_drained();

		write_size(sqi_pkg::REG_IMAGE_WIDTH, 11'd2);
		write_size(sqi_pkg::REG_IMAGE_HEIGHT, 11'd2);
		repeat (4) send_pixel(8'hFF);
		wait_drained();

		// Widen on a frame boundary, then cut the height mid-row
		write_size(sqi_pkg::REG_IMAGE_WIDTH, 11'd4);
		send_pixel(8'hAA);
		send_pixel(8'h55);
		wait_drained();
		write_size(sqi_pkg::REG_IMAGE_HEIGHT, 11'd1);
		send_pixel(8'hFF);
		send_pixel(8'hFF);
		wait_drained();

		// Oversized registers saturate: one full row of 1024 and a little more,
		// with a long hold-off at the receiver and no idling otherwise
		write_size(sqi_pkg::REG_IMAGE_WIDTH, 11'd2047);
		write_size(sqi_pkg::REG_IMAGE_HEIGHT, 11'd1100);
		src_idle_pct = 0;
		snk_idle_pct = 0;
		holdoff_req++;
		repeat (1030) send_pixel(random_pixel());
		wait_drained();
		src_idle_pct = 38;
		snk_idle_pct = 38;

		// Random phases of mostly small frames, sizes changed between phases
		random_items = 0;
		phase        = 0;
		while (random_items < 350) begin
			phase++;
			r = $urandom_range(99);
			if (r < 5)
				new_w = 11'd0;
			else if (r < 80)
				new_w = 11'($urandom_range(1, 12));
			else
				new_w = 11'($urandom_range(13, 80));
			// never widen past what the line buffer holds while rows above are in use
			if (row_pos != 0 && size_in_use(new_w, MAX_COLS) > written_hi)
				new_w = 11'(written_hi);
			new_h = ($urandom_range(99) < 5) ? 11'd0 : 11'($urandom_range(1, 6));
			sel = $urandom_range(2);
			if (sel != 1)
				write_size(sqi_pkg::REG_IMAGE_WIDTH, new_w);
			if (sel != 0)
				write_size(sqi_pkg::REG_IMAGE_HEIGHT, new_h);

			if (phase % 9 == 4) begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end else begin
				src_idle_pct = 38;
				snk_idle_pct = 38;
			end
			if (phase == 10) begin
				src_idle_pct = 0;
				holdoff_req++;
			end

			area = size_in_use(cfg_width, MAX_COLS) * size_in_use(cfg_height, MAX_ROWS);
			n = $urandom_range(1, (area * 3 > 120) ? 120 : area * 3);
			repeat (n) send_pixel(random_pixel());
			random_items += n;
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
